@@ rtl/core/cube_bit_permutation_engine_macros.svh @@
// assertion macros shared by the cube bit permutation engine rtl
// expects clk and rst_n in the scope of every use
`ifndef CUBE_BIT_PERMUTATION_ENGINE_MACROS_SVH
`define CUBE_BIT_PERMUTATION_ENGINE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CBPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cbpe_pkg.sv @@
// shared types, constants and primitive mapping functions of the cube bit
// permutation engine; no dependencies
`default_nettype none

package cbpe_pkg;

  localparam int BLOCK_BITS = 96;
  localparam int IDX_W      = 7;
  localparam int OP_W       = 2;
  localparam int PRIM_W     = 6;
  localparam int LOW_W      = 64;
  localparam int HIGH_W     = 32;
  localparam int NUM_FACES  = 6;
  localparam int NUM_ROWS   = 4;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BLOCK_BITS - 1);
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(BLOCK_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_RESET   = 2'd0,
    OP_COMPOSE = 2'd1,
    OP_FWD     = 2'd2,
    OP_INV     = 2'd3
  } cbpe_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PK_NONE,
    PK_FACE,
    PK_ROW,
    PK_XSLICE,
    PK_YSLICE
  } prim_kind_t;

  typedef struct packed {
    prim_kind_t  kind;
    logic [2:0]  layer;
    logic [1:0]  variant;
  } prim_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } tbl_ctrl_t;

  // primitive number -> kind, layer and variant
  function automatic prim_t prim_decode(input logic [PRIM_W-1:0] k);
    prim_t p;
    p.kind    = PK_NONE;
    p.layer   = '0;
    p.variant = '0;
    for (int l = 0; l < NUM_FACES; l++) begin
      if (k >= PRIM_W'(3 * l) && k < PRIM_W'(3 * l + 3)) begin
        p.kind    = PK_FACE;
        p.layer   = 3'(l);
        p.variant = 2'(k - PRIM_W'(3 * l));
      end
    end
    for (int l = 0; l < NUM_ROWS; l++) begin
      if (k >= PRIM_W'(18 + 3 * l) && k < PRIM_W'(21 + 3 * l)) begin
        p.kind    = PK_ROW;
        p.layer   = 3'(l);
        p.variant = 2'(k - PRIM_W'(18 + 3 * l));
      end
    end
    if (k >= PRIM_W'(30) && k < PRIM_W'(33)) begin
      p.kind  = PK_XSLICE;
      p.layer = 3'(k - PRIM_W'(30));
    end
    if (k >= PRIM_W'(33) && k < PRIM_W'(36)) begin
      p.kind  = PK_YSLICE;
      p.layer = 3'(k - PRIM_W'(33));
    end
    return p;
  endfunction

  // where a primitive sends cube position q
  function automatic logic [IDX_W-1:0] prim_dest(input prim_t p, input logic [IDX_W-1:0] q);
    logic [1:0] x, y, nx, ny;
    logic [2:0] z, nz, zinc;
    x    = q[1:0];
    y    = q[3:2];
    z    = q[6:4];
    nx   = x;
    ny   = y;
    nz   = z;
    zinc = (z == 3'd5) ? 3'd0 : z + 3'd1;
    case (p.kind)
      PK_FACE: begin
        if (z == p.layer) begin
          case (p.variant)
            2'd0: begin nx = ~y; ny = x; end
            2'd1: begin nx = y; ny = ~x; end
            default: begin nx = ~x; ny = ~y; end
          endcase
        end
      end
      PK_ROW: begin
        if (z == p.layer) begin
          case (p.variant)
            2'd0: ny = y + 2'd1;
            2'd1: ny = y - 2'd1;
            default: nx = x + 2'd1;
          endcase
        end
      end
      PK_XSLICE: if ({1'b0, x} == p.layer) nz = zinc;
      PK_YSLICE: if ({1'b0, y} == p.layer) nz = zinc;
      default: nz = z;
    endcase
    return (q >= IDX_LIMIT) ? q : {nz, ny, nx};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cbpe_in_if.sv @@
// request channel into the cube bit permutation engine
// depends on cbpe_pkg for field widths
`default_nettype none

interface cbpe_in_if;
  logic                           valid;
  logic                           ready;
  logic [cbpe_pkg::OP_W-1:0]      op;
  logic [cbpe_pkg::PRIM_W-1:0]    prim_index;
  logic [cbpe_pkg::LOW_W-1:0]     block_low;
  logic [cbpe_pkg::HIGH_W-1:0]    block_high;

  modport source (output valid, op, prim_index, block_low, block_high, input ready);
  modport sink   (input valid, op, prim_index, block_low, block_high, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cbpe_out_if.sv @@
// result channel out of the cube bit permutation engine
// depends on cbpe_pkg for field widths
`default_nettype none

interface cbpe_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbpe_pkg::LOW_W-1:0]  out_low;
  logic [cbpe_pkg::HIGH_W-1:0] out_high;

  modport source (output valid, out_low, out_high, input ready);
  modport sink   (input valid, out_low, out_high, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cbpe_table.sv @@
// permutation table: 96 x 7 memory, one write and one registered read a cycle,
// with per-entry valid flops so that an unwritten entry reads as its own index
`default_nettype none
`include "cube_bit_permutation_engine_macros.svh"

module cbpe_table (
  input  wire                          clk,
  input  wire                          rst_n,
  input  cbpe_pkg::tbl_ctrl_t          ctrl,
  output logic [cbpe_pkg::IDX_W-1:0]   entry
);

  logic [cbpe_pkg::IDX_W-1:0]      mem [cbpe_pkg::BLOCK_BITS];
  logic [cbpe_pkg::BLOCK_BITS-1:0] valid_r;
  logic [cbpe_pkg::IDX_W-1:0]      rd_data_r;
  logic [cbpe_pkg::IDX_W-1:0]      rd_idx_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ctrl.rd_addr];
      rd_idx_r  <= ctrl.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        valid_r <= '0;
      end else if (ctrl.wr_en) begin
        valid_r[ctrl.wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld_r <= valid_r[ctrl.rd_addr];
      end
    end
  end

  // identity for entries not written since the last clear
  assign entry = rd_vld_r ? rd_data_r : rd_idx_r;

  `CBPE_ASSERT_NXT(a_wr_sets_valid, ctrl.wr_en && !ctrl.clear, valid_r[$past(ctrl.wr_addr)], "written entry not marked valid")
  `CBPE_ASSERT_NXT(a_clear_all, ctrl.clear, valid_r == '0, "clear left a valid entry")
  `CBPE_ASSERT_NXT(a_entry_range, ctrl.rd_en, entry < cbpe_pkg::IDX_LIMIT, "table entry out of range")

endmodule

`default_nettype wire

@@ rtl/core/cube_bit_permutation_engine.sv @@
// cube bit permutation engine top level: control sequencer and bit-serial datapath
// depends on cbpe_pkg, cbpe_in_if, cbpe_out_if, cbpe_table and the macros header
//
// usage:
//   in_ch carries requests {op, prim_index, block_low, block_high}; out_ch
//   carries results {out_low, out_high}. a request is taken when valid and
//   ready are both high; ready is high only while the sequencer is idle.
//   op reset clears the permutation back to identity and gives no result.
//   op compose walks all 96 table entries, one a cycle through the single
//   read and write port of the table memory, then drains; it stays idle when
//   the primitive number is 36 or above, and gives no result.
//   op apply forward / inverse walks the table the same way, moving one block
//   bit per cycle through the source and result shift registers; the result
//   goes to the output register after the walk and drain, and the next
//   request is taken only once it has been loaded there.
//   the result sits in an output register: if the receiver stalls, it holds
//   and the block still takes and runs new requests; a second finished result
//   waits in the sequencer until the register frees.
//   reset (rst_n low, synchronous) sets the table to identity and empties the
//   output register; no clearing pass is needed.
`default_nettype none
`include "cube_bit_permutation_engine_macros.svh"

module cube_bit_permutation_engine (
  input  wire         clk,
  input  wire         rst_n,
  cbpe_in_if.sink     in_ch,
  cbpe_out_if.source  out_ch
);

  cbpe_pkg::state_t                 state_r, state_nxt;
  cbpe_pkg::cbpe_op_t               op_r, in_op;
  cbpe_pkg::prim_t                  prim_r, in_prim;
  cbpe_pkg::tbl_ctrl_t              tbl_ctrl;
  logic [cbpe_pkg::IDX_W-1:0]       cnt_r;
  logic [cbpe_pkg::IDX_W-1:0]       idx_r;
  logic                             p1_valid_r;
  logic [cbpe_pkg::BLOCK_BITS-1:0]  src_r;
  logic [cbpe_pkg::BLOCK_BITS-1:0]  dst_r;
  logic [cbpe_pkg::IDX_W-1:0]       entry;
  logic                             entry_ok;
  logic                             in_accept;
  logic                             load_out;
  logic                             is_apply;
  logic                             out_valid_r;
  logic [cbpe_pkg::LOW_W-1:0]       out_low_r;
  logic [cbpe_pkg::HIGH_W-1:0]      out_high_r;

  assign in_op     = cbpe_pkg::cbpe_op_t'(in_ch.op);
  assign in_prim   = cbpe_pkg::prim_decode(in_ch.prim_index);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign is_apply  = (op_r == cbpe_pkg::OP_FWD) || (op_r == cbpe_pkg::OP_INV);
  assign entry_ok  = entry < cbpe_pkg::IDX_LIMIT;

  cbpe_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (tbl_ctrl),
    .entry (entry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbpe_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_op)
            cbpe_pkg::OP_RESET:   state_nxt = cbpe_pkg::ST_IDLE;
            cbpe_pkg::OP_COMPOSE: state_nxt = (in_prim.kind == cbpe_pkg::PK_NONE) ?
                                              cbpe_pkg::ST_IDLE : cbpe_pkg::ST_WALK;
            default:              state_nxt = cbpe_pkg::ST_WALK;
          endcase
        end
      end
      cbpe_pkg::ST_WALK: begin
        if (cnt_r == cbpe_pkg::LAST_IDX) state_nxt = cbpe_pkg::ST_DRAIN;
      end
      cbpe_pkg::ST_DRAIN: begin
        state_nxt = is_apply ? cbpe_pkg::ST_EMIT : cbpe_pkg::ST_IDLE;
      end
      cbpe_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = cbpe_pkg::ST_IDLE;
      end
      default: state_nxt = cbpe_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready      = (state_r == cbpe_pkg::ST_IDLE);
    load_out         = (state_r == cbpe_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
    tbl_ctrl.clear   = in_accept && (in_op == cbpe_pkg::OP_RESET);
    tbl_ctrl.rd_en   = (state_r == cbpe_pkg::ST_WALK);
    tbl_ctrl.rd_addr = cnt_r;
    tbl_ctrl.wr_en   = p1_valid_r && (op_r == cbpe_pkg::OP_COMPOSE);
    tbl_ctrl.wr_addr = idx_r;
    tbl_ctrl.wr_data = cbpe_pkg::prim_dest(prim_r, entry);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbpe_pkg::ST_IDLE;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= (state_r == cbpe_pkg::ST_WALK);
      if (in_accept) begin
        cnt_r <= '0;
      end else if (state_r == cbpe_pkg::ST_WALK && cnt_r != cbpe_pkg::LAST_IDX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bit-serial datapath
  always_ff @(posedge clk) begin
    idx_r <= cnt_r;
    if (in_accept) begin
      op_r   <= in_op;
      prim_r <= in_prim;
      src_r  <= {in_ch.block_high, in_ch.block_low};
      dst_r  <= '0;
    end else if (p1_valid_r && op_r == cbpe_pkg::OP_FWD) begin
      // source bit idx_r sits at the bottom of the shifter
      src_r <= src_r >> 1;
      if (entry_ok && src_r[0]) dst_r[entry] <= 1'b1;
    end else if (p1_valid_r && op_r == cbpe_pkg::OP_INV) begin
      // result bits enter at the top and settle at their index after 96 shifts
      dst_r <= {entry_ok && src_r[entry], dst_r[cbpe_pkg::BLOCK_BITS-1:1]};
    end
    if (load_out) begin
      out_low_r  <= dst_r[cbpe_pkg::LOW_W-1:0];
      out_high_r <= dst_r[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_low  = out_low_r;
  assign out_ch.out_high = out_high_r;

  `CBPE_ASSERT_NXT(a_apply_walks, in_accept && (in_op == cbpe_pkg::OP_FWD || in_op == cbpe_pkg::OP_INV), state_r == cbpe_pkg::ST_WALK, "apply request did not start a walk")
  `CBPE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= cbpe_pkg::LAST_IDX, "walk counter past last entry")
  `CBPE_ASSERT_NOW(a_emit_apply, state_r == cbpe_pkg::ST_EMIT, op_r == cbpe_pkg::OP_FWD || op_r == cbpe_pkg::OP_INV, "result emitted for a non-apply request")
  `CBPE_ASSERT_NOW(a_p1_after_walk, p1_valid_r, $past(state_r) == cbpe_pkg::ST_WALK, "table entry processed without a read")

endmodule

`default_nettype wire

@@ dv/tb_cube_bit_permutation_engine.sv @@
// testbench for the cube bit permutation engine: directed, random and output stall tests
// depends on cbpe_pkg, cbpe_in_if, cbpe_out_if and the cube_bit_permutation_engine rtl
`timescale 1ns / 1ps

module tb_cube_bit_permutation_engine;

  localparam int PRIM_COUNT   = 36;
  localparam int HOLD_CYCLES  = 2000;
  localparam int DRAIN_CYCLES = 150;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int RANDOM_ITEMS = 1700;

  // primitive variants within a group of three
  localparam int TURN_CW   = 0;
  localparam int TURN_CCW  = 1;
  localparam int ROW_UP    = 0;
  localparam int ROW_DOWN  = 1;

  typedef struct packed {
    logic [cbpe_pkg::LOW_W-1:0]  low;
    logic [cbpe_pkg::HIGH_W-1:0] high;
  } block_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbpe_in_if  in_ch ();
  cbpe_out_if out_ch ();

  cube_bit_permutation_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [cbpe_pkg::IDX_W-1:0] route_map [cbpe_pkg::BLOCK_BITS];
  block_t                     expected_blocks [$];
  int                         error_count = 0;
  int                         burst_left = 0;
  int unsigned                cycle_count = 0;
  logic [7:0]                 hold_tag = '0;

  // where primitive k moves cube position q
  function automatic logic [cbpe_pkg::IDX_W-1:0] cube_move(input int unsigned k,
                                                           input logic [cbpe_pkg::IDX_W-1:0] q);
    int unsigned qi, x, y, z, nx, ny, nz, grp, v;
    qi = q;
    if (qi >= cbpe_pkg::BLOCK_BITS) return q;
    x  = qi % 4;
    y  = (qi / 4) % 4;
    z  = qi / 16;
    nx = x;
    ny = y;
    nz = z;
    if (k < 18) begin
      grp = k / 3;
      v   = k % 3;
      if (z == grp) begin
        if (v == TURN_CW) begin
          nx = 3 - y; ny = x;
        end else if (v == TURN_CCW) begin
          nx = y; ny = 3 - x;
        end else begin
          nx = 3 - x; ny = 3 - y;
        end
      end
    end else if (k < 30) begin
      grp = (k - 18) / 3;
      v   = (k - 18) % 3;
      if (z == grp) begin
        if (v == ROW_UP) ny = (y + 1) % 4;
        else if (v == ROW_DOWN) ny = (y + 3) % 4;
        else nx = (x + 1) % 4;
      end
    end else if (k < 33) begin
      if (x == k - 30) nz = (z + 1) % 6;
    end else if (k < PRIM_COUNT) begin
      if (y == k - 33) nz = (z + 1) % 6;
    end
    return cbpe_pkg::IDX_W'(nz * 16 + ny * 4 + nx);
  endfunction

  function automatic void restore_identity();
    for (int i = 0; i < cbpe_pkg::BLOCK_BITS; i++) route_map[i] = cbpe_pkg::IDX_W'(i);
  endfunction

  // update the table or queue the permuted block, as the request asks
  function automatic void predict_request(input cbpe_pkg::cbpe_op_t op,
                                          input logic [cbpe_pkg::PRIM_W-1:0] prim,
                                          input logic [cbpe_pkg::LOW_W-1:0] lo,
                                          input logic [cbpe_pkg::HIGH_W-1:0] hi);
    logic [cbpe_pkg::BLOCK_BITS-1:0] src, dst;
    int unsigned p;
    block_t res;
    src = {hi, lo};
    dst = '0;
    case (op)
      cbpe_pkg::OP_RESET: restore_identity();
      cbpe_pkg::OP_COMPOSE: begin
        if (prim < PRIM_COUNT)
          for (int i = 0; i < cbpe_pkg::BLOCK_BITS; i++)
            route_map[i] = cube_move(prim, route_map[i]);
      end
      default: begin
        for (int i = 0; i < cbpe_pkg::BLOCK_BITS; i++) begin
          p = route_map[i];
          if (p < cbpe_pkg::BLOCK_BITS) begin
            if (op == cbpe_pkg::OP_FWD) dst[p] = dst[p] | src[i];
            else dst[i] = src[p];
          end
        end
        res.low  = dst[cbpe_pkg::LOW_W-1:0];
        res.high = dst[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W];
        expected_blocks.push_back(res);
      end
    endcase
  endfunction

  // one request, in bursts with random gaps between them
  task automatic send_request(input cbpe_pkg::cbpe_op_t op,
                              input logic [cbpe_pkg::PRIM_W-1:0] prim,
                              input logic [cbpe_pkg::LOW_W-1:0] lo,
                              input logic [cbpe_pkg::HIGH_W-1:0] hi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.prim_index <= prim;
    in_ch.block_low  <= lo;
    in_ch.block_high <= hi;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(op, prim, lo, hi);
  endtask

  function automatic logic [cbpe_pkg::BLOCK_BITS-1:0] random_block();
    logic [cbpe_pkg::BLOCK_BITS-1:0] b;
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = '1;
      2: b = {{(cbpe_pkg::BLOCK_BITS-1){1'b0}}, 1'b1}
             << $urandom_range(0, cbpe_pkg::BLOCK_BITS - 1);
      default: b = {$urandom, $urandom, $urandom};
    endcase
    return b;
  endfunction

  task automatic test_directed();
    send_request(cbpe_pkg::OP_FWD, '0, '0, '0);
    send_request(cbpe_pkg::OP_FWD, '1, '1, '1);
    send_request(cbpe_pkg::OP_INV, '0, 64'h1, '0);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd0, '0, '0);
    send_request(cbpe_pkg::OP_FWD, '0, 64'h1, 32'h8000_0000);
    send_request(cbpe_pkg::OP_INV, '0, '0, 32'h8000_0000);
    // numbers past the last primitive leave the table alone
    send_request(cbpe_pkg::OP_COMPOSE, 6'd36, '1, '1);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd63, '0, '0);
    send_request(cbpe_pkg::OP_FWD, 6'd63, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd17, '0, '0);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd20, '0, '0);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd29, '0, '0);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd30, '0, '0);
    send_request(cbpe_pkg::OP_COMPOSE, 6'd35, '0, '0);
    send_request(cbpe_pkg::OP_FWD, '0, 64'hAAAA_AAAA_5555_5555, 32'hF0F0_0F0F);
    send_request(cbpe_pkg::OP_INV, '0, 64'hAAAA_AAAA_5555_5555, 32'hF0F0_0F0F);
    send_request(cbpe_pkg::OP_INV, '0, '1, '1);
    send_request(cbpe_pkg::OP_RESET, '1, '1, '1);
    send_request(cbpe_pkg::OP_FWD, '0, 64'h8000_0000_0000_0001, 32'h0000_0001);
    send_request(cbpe_pkg::OP_INV, '0, 64'hFEDC_BA98_7654_3210, 32'h1234_5678);
  endtask

  // long compose chains with applies in between, rare resets and ignored fields as noise
  task automatic test_random_mix();
    int sel;
    logic [cbpe_pkg::PRIM_W-1:0] prim;
    logic [cbpe_pkg::BLOCK_BITS-1:0] blk;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel  = $urandom_range(0, 99);
      blk  = random_block();
      prim = cbpe_pkg::PRIM_W'($urandom_range(0, PRIM_COUNT - 1));
      if (sel < 3)
        send_request(cbpe_pkg::OP_RESET, cbpe_pkg::PRIM_W'($urandom),
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
      else if (sel < 8)
        send_request(cbpe_pkg::OP_COMPOSE, cbpe_pkg::PRIM_W'($urandom_range(PRIM_COUNT, 63)),
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
      else if (sel < 50)
        send_request(cbpe_pkg::OP_COMPOSE, prim,
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
      else if (sel < 75)
        send_request(cbpe_pkg::OP_FWD, cbpe_pkg::PRIM_W'($urandom),
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
      else
        send_request(cbpe_pkg::OP_INV, cbpe_pkg::PRIM_W'($urandom),
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
    end
  endtask

  // receiver holds off while applies keep coming, so the engine backs up to its input
  task automatic test_output_stall();
    logic [cbpe_pkg::BLOCK_BITS-1:0] blk;
    hold_tag <= hold_tag + 8'd1;
    for (int n = 0; n < 30; n++) begin
      blk = random_block();
      if (n % 5 == 4)
        send_request(cbpe_pkg::OP_COMPOSE,
                     cbpe_pkg::PRIM_W'($urandom_range(0, PRIM_COUNT - 1)), '0, '0);
      else
        send_request((n % 2) ? cbpe_pkg::OP_INV : cbpe_pkg::OP_FWD, '0,
                     blk[cbpe_pkg::LOW_W-1:0], blk[cbpe_pkg::BLOCK_BITS-1:cbpe_pkg::LOW_W]);
    end
  endtask

  // receiver: stall pattern of its own plus the long hold-off on request
  logic [7:0]  hold_seen = '0;
  int          hold_left = 0;
  int          phase_left = 0;
  logic [15:0] stall_pattern = '1;
  logic        free_run = 1'b1;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen     <= hold_tag;
      hold_left     <= HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (phase_left == 0) begin
      phase_left    <= $urandom_range(20, 400);
      free_run      <= ($urandom_range(0, 3) == 0);
      stall_pattern <= ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom | $urandom);
      out_ch.ready  <= 1'b1;
    end else begin
      phase_left   <= phase_left - 1;
      out_ch.ready <= free_run | stall_pattern[phase_left % 16];
    end
  end

  // result checker
  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("result with no request waiting: out_low %h out_high %h",
               out_ch.out_low, out_ch.out_high);
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_ch.out_low !== want.low) begin
          $error("out_low mismatch: expected %h, got %h", want.low, out_ch.out_low);
          error_count++;
        end
        if (out_ch.out_high !== want.high) begin
          $error("out_high mismatch: expected %h, got %h", want.high, out_ch.out_high);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = cbpe_pkg::OP_RESET;
    in_ch.prim_index = '0;
    in_ch.block_low  = '0;
    in_ch.block_high = '0;
    restore_identity();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_output_stall();
    in_ch.valid <= 1'b0;

    while (expected_blocks.size() != 0) @(posedge clk);
    // a trailing compose gives no result, so let it run out too
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cbpe_pkg.sv
rtl/core/cbpe_in_if.sv
rtl/core/cbpe_out_if.sv
rtl/core/cbpe_table.sv
rtl/core/cube_bit_permutation_engine.sv
dv/tb_cube_bit_permutation_engine.sv
